/* hdl/lls_pkg.sv */
// Shared widths, constants and the memory control bundle of the least-loaded list scheduler.
package lls_pkg;

  localparam int unsigned LOAD_W  = 32;
  localparam int unsigned PTIME_W = 16;
  localparam int unsigned TAG_W   = 16;
  localparam int unsigned MACH_W  = 4;
  localparam int unsigned CFG_W   = 5;

  localparam logic [CFG_W-1:0]  CFG_RESET = 5'd2;
  localparam logic [LOAD_W-1:0] LOAD_MAX  = 32'hFFFF_FFFF;

  typedef logic [LOAD_W-1:0]  load_t;
  typedef logic [PTIME_W-1:0] ptime_t;
  typedef logic [TAG_W-1:0]   tag_t;
  typedef logic [MACH_W-1:0]  mach_t;
  typedef logic [CFG_W-1:0]   cfg_t;

  // Control bundle from the scan controller to the load store.
  typedef struct packed {
    logic rd_en;
    logic wr_en;
    logic clear_all;
  } mem_ctl_t;

endpackage

/* hdl/lls_if.sv */
// Valid/ready interfaces for the job items and the result items.
interface lls_job_if;
  import lls_pkg::*;

  logic   valid;
  logic   ready;
  ptime_t processing_time;
  tag_t   job_id;
  logic   first_job;

  modport source (output valid, output processing_time, output job_id, output first_job,
                  input ready);
  modport sink (input valid, input processing_time, input job_id, input first_job,
                output ready);
endinterface

interface lls_res_if;
  import lls_pkg::*;

  logic  valid;
  logic  ready;
  tag_t  job_tag;
  mach_t assigned_machine;
  load_t machine_load;
  load_t makespan;

  modport source (output valid, output job_tag, output assigned_machine, output machine_load,
                  output makespan, input ready);
  modport sink (input valid, input job_tag, input assigned_machine, input machine_load,
                input makespan, output ready);
endinterface

/* hdl/least_loaded_list_scheduler.sv */
// Top level of the least-loaded list scheduler: configuration register, controller and load store.
//
// Each job goes to the machine with the smallest load among the machines in use, the
// machine chosen last winning ties, and the result reports the machine, its new
// saturating load and the running makespan. One job is handled at a time: the controller
// reads the starting machine, then scans the loads of the n machines in one memory with
// a single read port, one machine per cycle, where n is the effective machine count (the
// configured count clamped to 1..MAX_MACHINES), and then writes the new load back. A new
// job is accepted only after the last one has written its load back. The result waits in
// an output register, and the next job is accepted while it is pending; that job's
// write-back waits until the register is free.
// A job with first_job set clears all loads at once through per-entry valid bits.
module least_loaded_list_scheduler #(
  parameter int unsigned MAX_MACHINES = 16
) (
  input  logic          clk_i,
  input  logic          rst_ni,
  input  logic          cfg_we_i,
  input  lls_pkg::cfg_t cfg_wdata_i,
  lls_job_if.sink       job_i,
  lls_res_if.source     res_o
);
  import lls_pkg::*;

  localparam int unsigned IDX_W = (MAX_MACHINES > 1) ? $clog2(MAX_MACHINES) : 1;
  localparam int unsigned CNT_W = $clog2(MAX_MACHINES + 1);

  cfg_t             cfg_q;
  logic [CNT_W-1:0] count;
  mem_ctl_t         ctl;
  logic [IDX_W-1:0] rd_addr;
  logic [IDX_W-1:0] wr_addr;
  load_t            wr_data;
  load_t            rd_load;

  // Machine count register.
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      cfg_q <= CFG_RESET;
    end else if (cfg_we_i) begin
      cfg_q <= cfg_wdata_i;
    end
  end

  // Effective machine count: zero counts as one, large values clamp to the built count.
  always_comb begin
    if (cfg_q == '0) begin
      count = CNT_W'(1);
    end else if (32'(cfg_q) > MAX_MACHINES) begin
      count = CNT_W'(MAX_MACHINES);
    end else begin
      count = CNT_W'(cfg_q);
    end
  end

  lls_scan_ctrl #(
    .MAX_MACHINES (MAX_MACHINES),
    .IDX_W        (IDX_W),
    .CNT_W        (CNT_W)
  ) u_ctrl (
    .clk_i     (clk_i),
    .rst_ni    (rst_ni),
    .count_i   (count),
    .job_i     (job_i),
    .res_o     (res_o),
    .ctl_o     (ctl),
    .rd_addr_o (rd_addr),
    .wr_addr_o (wr_addr),
    .wr_data_o (wr_data),
    .rd_load_i (rd_load)
  );

  lls_load_store #(
    .MAX_MACHINES (MAX_MACHINES),
    .IDX_W        (IDX_W)
  ) u_store (
    .clk_i     (clk_i),
    .rst_ni    (rst_ni),
    .ctl_i     (ctl),
    .rd_addr_i (rd_addr),
    .wr_addr_i (wr_addr),
    .wr_data_i (wr_data),
    .rd_load_o (rd_load)
  );

endmodule

/* hdl/lls_load_store.sv */
// Machine load memory with one registered read port, one write port and per-entry valid bits.
module lls_load_store #(
  parameter int unsigned MAX_MACHINES = 16,
  parameter int unsigned IDX_W        = (MAX_MACHINES > 1) ? $clog2(MAX_MACHINES) : 1
) (
  input  logic                  clk_i,
  input  logic                  rst_ni,
  input  lls_pkg::mem_ctl_t     ctl_i,
  input  logic [IDX_W-1:0]      rd_addr_i,
  input  logic [IDX_W-1:0]      wr_addr_i,
  input  lls_pkg::load_t        wr_data_i,
  output lls_pkg::load_t        rd_load_o
);
  import lls_pkg::*;

  load_t                   mem [MAX_MACHINES];
  logic [MAX_MACHINES-1:0] valid_q;
  load_t                   rd_data_q;
  logic                    rd_vld_q;

  // Load array: plain synchronous write and registered read.
  always_ff @(posedge clk_i) begin
    if (ctl_i.wr_en) begin
      mem[wr_addr_i] <= wr_data_i;
    end
    if (ctl_i.rd_en) begin
      rd_data_q <= mem[rd_addr_i];
    end
  end

  // Valid bits: a cleared entry reads as zero load until it is written again.
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      valid_q  <= '0;
      rd_vld_q <= 1'b0;
    end else begin
      if (ctl_i.clear_all) begin
        valid_q <= '0;
      end else if (ctl_i.wr_en) begin
        valid_q[wr_addr_i] <= 1'b1;
      end
      if (ctl_i.rd_en) begin
        rd_vld_q <= valid_q[rd_addr_i];
      end
    end
  end

  assign rd_load_o = rd_vld_q ? rd_data_q : '0;

endmodule

/* hdl/lls_scan_ctrl.sv */
// Scan controller: takes a job, walks the load memory for the least load, writes back, reports.
module lls_scan_ctrl #(
  parameter int unsigned MAX_MACHINES = 16,
  parameter int unsigned IDX_W        = (MAX_MACHINES > 1) ? $clog2(MAX_MACHINES) : 1,
  parameter int unsigned CNT_W        = $clog2(MAX_MACHINES + 1)
) (
  input  logic              clk_i,
  input  logic              rst_ni,
  input  logic [CNT_W-1:0]  count_i,
  lls_job_if.sink           job_i,
  lls_res_if.source         res_o,
  output lls_pkg::mem_ctl_t ctl_o,
  output logic [IDX_W-1:0]  rd_addr_o,
  output logic [IDX_W-1:0]  wr_addr_o,
  output lls_pkg::load_t    wr_data_o,
  input  lls_pkg::load_t    rd_load_i
);
  import lls_pkg::*;

  typedef enum logic [1:0] {
    ST_IDLE,
    ST_SEED,
    ST_SCAN,
    ST_FINISH
  } state_e;

  state_e           state_q;
  ptime_t           ptime_q;
  tag_t             tag_q;
  logic [CNT_W-1:0] cnt_q;
  logic [IDX_W-1:0] pick_q;
  load_t            best_q;
  mach_t            last_q;
  load_t            span_q;

  logic             out_valid_q;
  tag_t             out_tag_q;
  mach_t            out_mach_q;
  load_t            out_load_q;
  load_t            out_span_q;

  logic             accept;
  logic             out_free;
  logic             commit;
  logic [IDX_W-1:0] start_idx;
  logic [LOAD_W:0]  sum;
  load_t            new_load;
  load_t            new_span;

  assign accept   = job_i.valid && job_i.ready;
  assign out_free = !out_valid_q || res_o.ready;
  assign commit   = (state_q == ST_FINISH) && out_free;

  // A stale last machine (count lowered since) restarts the search at machine zero.
  assign start_idx = (32'(last_q) < 32'(count_i)) ? IDX_W'(last_q) : '0;

  // Saturating add of the job onto the chosen load, and the running maximum.
  assign sum      = {1'b0, best_q} + {{(LOAD_W + 1 - PTIME_W){1'b0}}, ptime_q};
  assign new_load = sum[LOAD_W] ? LOAD_MAX : sum[LOAD_W-1:0];
  assign new_span = (new_load > span_q) ? new_load : span_q;

  // Memory requests. Reads happen only in the seed and scan states and writes only at commit,
  // so one job never reads an entry while its own write to it is pending.
  always_comb begin
    ctl_o.rd_en     = 1'b0;
    ctl_o.wr_en     = commit;
    ctl_o.clear_all = accept && job_i.first_job;
    rd_addr_o       = cnt_q[IDX_W-1:0];
    case (state_q)
      ST_SEED: begin
        ctl_o.rd_en = 1'b1;
        rd_addr_o   = start_idx;
      end
      ST_SCAN: begin
        ctl_o.rd_en = (cnt_q != count_i);
      end
      default: begin
        ctl_o.rd_en = 1'b0;
      end
    endcase
  end

  assign wr_addr_o = pick_q;
  assign wr_data_o = new_load;

  // State, job registers and the result register.
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q     <= ST_IDLE;
      last_q      <= '0;
      span_q      <= '0;
      cnt_q       <= '0;
      out_valid_q <= 1'b0;
    end else begin
      // A taken result frees the output register unless a new one lands in it now.
      if (res_o.ready && !commit) begin
        out_valid_q <= 1'b0;
      end
      case (state_q)
        ST_IDLE: begin
          if (accept) begin
            ptime_q <= job_i.processing_time;
            tag_q   <= job_i.job_id;
            if (job_i.first_job) begin
              last_q <= '0;
              span_q <= '0;
            end
            state_q <= ST_SEED;
          end
        end
        ST_SEED: begin
          pick_q  <= start_idx;
          cnt_q   <= '0;
          state_q <= ST_SCAN;
        end
        ST_SCAN: begin
          // The data on hand belongs to the previous request: the seed first,
          // then machine cnt_q - 1. Only a strictly smaller load takes over.
          if (cnt_q == '0) begin
            best_q <= rd_load_i;
          end else if (rd_load_i < best_q) begin
            best_q <= rd_load_i;
            pick_q <= IDX_W'(cnt_q - 1'b1);
          end
          if (cnt_q == count_i) begin
            state_q <= ST_FINISH;
          end else begin
            cnt_q <= cnt_q + 1'b1;
          end
        end
        ST_FINISH: begin
          if (out_free) begin
            last_q      <= MACH_W'(pick_q);
            span_q      <= new_span;
            out_valid_q <= 1'b1;
            out_tag_q   <= tag_q;
            out_mach_q  <= MACH_W'(pick_q);
            out_load_q  <= new_load;
            out_span_q  <= new_span;
            state_q     <= ST_IDLE;
          end
        end
        default: begin
          state_q <= ST_IDLE;
        end
      endcase
    end
  end

  assign job_i.ready            = (state_q == ST_IDLE);
  assign res_o.valid            = out_valid_q;
  assign res_o.job_tag          = out_tag_q;
  assign res_o.assigned_machine = out_mach_q;
  assign res_o.machine_load     = out_load_q;
  assign res_o.makespan         = out_span_q;

endmodule
